@@ rtl/g711_pkg.sv @@
// Package for the G.711 companding codec.
// Holds the law and operation codes and the companding constants.
// No dependencies.
package g711_pkg;

  localparam logic LAW_MU = 1'b0;
  localparam logic LAW_A  = 1'b1;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam logic [11:0] A_MAG_MAX  = 12'hFFF;
  localparam logic [12:0] MU_MAG_MAX = 13'h1FFF;
  localparam logic [5:0]  MU_BIAS    = 6'd33;
  localparam logic [7:0]  A_XOR      = 8'h55;

  localparam logic signed [13:0] SAMPLE_MAX = 14'sd8031;

endpackage

@@ rtl/g711_companding_codec_core.sv @@
// G.711 codec top level: three-stage pipeline for A-law and mu-law words.
// Throughput one word per cycle while out_ready is high; a stall at the output backs up through the stages.
// Stage 1 takes magnitude and saturation, stage 2 the segment search and decode
// expansion, stage 3 the code build and signed result into the output register.
// Reset clears all stage valid bits and sets the law register to A-law.
// Depends on g711_pkg and g711_enc.
module g711_companding_codec_core
  import g711_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_law,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [15:0] sample_in,
  input  logic        [7:0]  code_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [7:0]  code_out,
  output logic signed [13:0] sample_out
);

  typedef struct packed {
    logic        op;
    logic        law;
    logic        sign;
    logic [12:0] mag;
    logic [7:0]  n;
  } s1_t;

  typedef struct packed {
    logic        op;
    logic        law;
    logic        sign;
    logic [2:0]  seg;
    logic [3:0]  mant;
    logic        dneg;
    logic [12:0] dval;
  } s2_t;

  logic law;
  logic valid1, valid2, valid3;
  logic adv1, adv2, adv3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  logic [7:0]         code_next;
  logic signed [13:0] sample_next;

  logic [15:0] abs16;
  logic [16:0] mu_sum;
  logic [2:0]  eseg;
  logic [3:0]  emant;
  logic [2:0]  dseg;
  logic [3:0]  dmant;
  logic [7:0]  cw;
  logic [13:0] val14;

  assign cfg_ready = 1'b1;
  assign adv3      = !valid3 || out_ready;
  assign adv2      = !valid2 || adv3;
  assign adv1      = !valid1 || adv2;
  assign in_ready  = adv1;
  assign out_valid = valid3;

  always_ff @(posedge clk) begin
    if (rst) begin
      law    <= LAW_A;
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        law <= cfg_law;
      end
      if (adv1) begin
        valid1 <= in_valid;
      end
      if (adv2) begin
        valid2 <= valid1;
      end
      if (adv3) begin
        valid3 <= valid2;
      end
    end
  end

  // Stage 1: magnitude, saturation, code unmasking
  always_comb begin
    abs16  = sample_in[15] ? ($unsigned(~sample_in) + 16'd1) : $unsigned(sample_in);
    mu_sum = {1'b0, abs16} + 17'(MU_BIAS);
    s1_next.op   = op;
    s1_next.law  = law;
    s1_next.sign = sample_in[15];
    if (law == LAW_A) begin
      s1_next.mag = (abs16 > 16'(A_MAG_MAX)) ? {1'b0, A_MAG_MAX} : abs16[12:0];
      s1_next.n   = code_in ^ A_XOR;
    end else begin
      s1_next.mag = (mu_sum > 17'(MU_MAG_MAX)) ? MU_MAG_MAX : mu_sum[12:0];
      s1_next.n   = ~code_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1 <= s1_next;
    end
  end

  // Stage 2: segment search and decode expansion
  g711_enc u_enc (
    .law  (s1.law),
    .mag  (s1.mag),
    .seg  (eseg),
    .mant (emant)
  );

  always_comb begin
    dseg  = s1.n[6:4];
    dmant = s1.n[3:0];
    s2_next.op   = s1.op;
    s2_next.law  = s1.law;
    s2_next.sign = s1.sign;
    s2_next.seg  = eseg;
    s2_next.mant = emant;
    s2_next.dneg = s1.n[7];
    if (s1.law == LAW_A) begin
      if (dseg == 3'd0) begin
        s2_next.dval = {8'd0, dmant, 1'b1};
      end else begin
        s2_next.dval = (13'd1 << ({1'b0, dseg} + 4'd4))
                     | ({9'd0, dmant} << dseg)
                     | (13'd1 << (dseg - 3'd1));
      end
    end else begin
      s2_next.dval = (13'd1 << ({1'b0, dseg} + 4'd5))
                   | ({9'd0, dmant} << ({1'b0, dseg} + 4'd1))
                   | (13'd1 << dseg);
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2 <= s2_next;
    end
  end

  // Stage 3: code build, bias removal and sign
  always_comb begin
    cw = {s2.sign, s2.seg, s2.mant};
    if (s2.law == LAW_A) begin
      val14 = {1'b0, s2.dval};
    end else begin
      val14 = {1'b0, s2.dval} - 14'(MU_BIAS);
    end
    if (s2.op == OP_ENC) begin
      code_next   = (s2.law == LAW_A) ? (cw ^ A_XOR) : ~cw;
      sample_next = 14'sd0;
    end else begin
      code_next   = 8'd0;
      sample_next = s2.dneg ? -$signed(val14) : $signed(val14);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      code_out   <= code_next;
      sample_out <= sample_next;
    end
  end

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (valid1 && valid2 && valid3 && !out_ready))
    else $error("input stalled while the pipeline has room");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (valid1 && adv2) |=> valid2)
    else $error("stage 1 word lost on advance");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid2 && !adv2) |=> (valid2 && $stable(s2)))
    else $error("stage 2 word changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_out <= SAMPLE_MAX && sample_out >= -SAMPLE_MAX))
    else $error("decoded sample out of range");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (code_out == 8'd0 || sample_out == 14'sd0))
    else $error("both result fields nonzero");

endmodule

@@ rtl/g711_enc.sv @@
// Encoder segment unit: leading-one search and mantissa extract.
// Takes a saturated magnitude and the law; depends on g711_pkg.
module g711_enc
  import g711_pkg::*;
(
  input  logic        law,
  input  logic [12:0] mag,
  output logic [2:0]  seg,
  output logic [3:0]  mant
);

  logic [2:0]  seg_a;
  logic [2:0]  seg_m;
  logic [3:0]  sh;
  logic [12:0] shifted;

  always_comb begin
    seg_a = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (mag[i+5]) begin
        seg_a = 3'(i + 1);
      end
    end
    seg_m = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i+5]) begin
        seg_m = 3'(i);
      end
    end
    if (law == LAW_A) begin
      seg = seg_a;
      sh  = (seg_a == 3'd0) ? 4'd1 : {1'b0, seg_a};
    end else begin
      seg = seg_m;
      sh  = {1'b0, seg_m} + 4'd1;
    end
    shifted = mag >> sh;
    mant    = shifted[3:0];
  end

endmodule

@@ dv/g711_codec_checker.sv @@
// Checker for the G.711 companding codec: watches the config, input and output channels.
// Predicts each result word for the selected law and compares it field by field.
// Depends on g711_pkg.
`timescale 1ns / 100ps
module g711_codec_checker
  import g711_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_law,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic signed [15:0] sample_in,
  input  logic        [7:0]  code_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic        [7:0]  code_out,
  input  logic signed [13:0] sample_out,
  output int                 mismatches,
  output int                 words_due
);

  typedef struct {
    logic               op;
    logic        [7:0]  code;
    logic signed [13:0] sample;
  } codec_word_t;

  codec_word_t due_words[$];
  logic        law_sel;

  initial begin
    mismatches = 0;
    words_due  = 0;
    law_sel    = LAW_A;
  end

  function automatic int magnitude_of(logic signed [15:0] s);
    int v;
    v = s;
    if (v < 0) v = (v == -32768) ? 32767 : -v;
    return v;
  endfunction

  function automatic logic [7:0] alaw_compress(logic signed [15:0] s);
    int mag;
    int pos;
    int sh;
    logic [2:0] seg;
    logic [3:0] mant;
    mag = magnitude_of(s);
    if (mag > int'(A_MAG_MAX)) mag = int'(A_MAG_MAX);
    pos = 11;
    while (pos >= 5 && mag[pos] == 1'b0) pos--;
    sh   = (pos == 4) ? 1 : pos - 4;
    seg  = 3'(pos - 4);
    mant = 4'(mag >> sh);
    return {s[15], seg, mant} ^ A_XOR;
  endfunction

  function automatic logic [7:0] mulaw_compress(logic signed [15:0] s);
    int mag;
    int pos;
    logic [2:0] seg;
    logic [3:0] mant;
    mag = magnitude_of(s) + int'(MU_BIAS);
    if (mag > int'(MU_MAG_MAX)) mag = int'(MU_MAG_MAX);
    pos = 12;
    while (pos > 5 && mag[pos] == 1'b0) pos--;
    seg  = 3'(pos - 5);
    mant = 4'(mag >> (pos - 4));
    return ~{s[15], seg, mant};
  endfunction

  function automatic logic signed [13:0] alaw_expand(logic [7:0] c);
    logic [7:0] n;
    int pos;
    int mant;
    int v;
    n    = c ^ A_XOR;
    pos  = int'(n[6:4]) + 4;
    mant = int'(n[3:0]);
    if (pos != 4) v = (1 << pos) | (mant << (pos - 4)) | (1 << (pos - 5));
    else v = mant * 2 + 1;
    if (n[7]) v = -v;
    return 14'(v);
  endfunction

  function automatic logic signed [13:0] mulaw_expand(logic [7:0] c);
    logic [7:0] n;
    int pos;
    int mant;
    int v;
    n    = ~c;
    pos  = int'(n[6:4]) + 5;
    mant = int'(n[3:0]);
    v    = ((1 << pos) | (mant << (pos - 4)) | (1 << (pos - 5))) - int'(MU_BIAS);
    if (n[7]) v = -v;
    return 14'(v);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    codec_word_t w;
    if (rst) begin
      due_words.delete();
      law_sel   = LAW_A;
      words_due = 0;
    end else begin
      if (cfg_valid && cfg_ready) law_sel = cfg_law;
      if (in_valid && in_ready) begin
        w.op = op;
        if (op == OP_ENC) begin
          w.code   = (law_sel == LAW_A) ? alaw_compress(sample_in) : mulaw_compress(sample_in);
          w.sample = '0;
        end else begin
          w.code   = '0;
          w.sample = (law_sel == LAW_A) ? alaw_expand(code_in) : mulaw_expand(code_in);
        end
        due_words.push_back(w);
      end
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word code_out=%h sample_out=%0d",
                                    code_out, sample_out));
        end else begin
          w = due_words.pop_front();
          if (code_out !== w.code)
            report_mismatch($sformatf("op=%0d code_out=%h, predicted %h",
                                      w.op, code_out, w.code));
          if (sample_out !== w.sample)
            report_mismatch($sformatf("op=%0d sample_out=%0d, predicted %0d",
                                      w.op, sample_out, w.sample));
        end
      end
      words_due = due_words.size();
    end
  end

endmodule

@@ dv/tb_g711_companding_codec_core.sv @@
// Testbench top for g711_companding_codec_core: drives law writes, encode and decode words
// with random gaps and output stalls, and gives the verdict.
// Depends on g711_pkg, the core and g711_codec_checker.
`timescale 1ns / 100ps
module tb_g711_companding_codec_core;
  import g711_pkg::*;

  localparam int STUCK_LIMIT    = 2000;
  localparam int SQUEEZE_CYCLES = 80;
  localparam int FLOOD_WORDS    = 40;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_law   = LAW_A;
  logic               in_valid  = 1'b0;
  logic               op        = OP_ENC;
  logic signed [15:0] sample_in = '0;
  logic        [7:0]  code_in   = '0;
  logic               out_ready = 1'b0;
  logic               cfg_ready;
  logic               in_ready;
  logic               out_valid;
  logic        [7:0]  code_out;
  logic signed [13:0] sample_out;

  int mismatches;
  int words_due;
  int stuck = 0;
  int encode_words = 0;
  int decode_words = 0;
  int law_writes = 0;
  int squeeze_asks = 0;
  int flood = 0;
  bit quiet = 1'b0;

  logic signed [15:0] corner_samples [15] = '{
    0, 1, -1, 31, 32, -33, 4095, 4096, -4096, 8158, 8159, -8160, 32767, -32767, -32768
  };
  logic [7:0] corner_codes [7] = '{8'h00, 8'hFF, 8'h55, 8'hD5, 8'h7F, 8'h80, 8'h2A};

  g711_companding_codec_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_law    (cfg_law),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .sample_in  (sample_in),
    .code_in    (code_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_out   (code_out),
    .sample_out (sample_out)
  );

  g711_codec_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_law    (cfg_law),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .sample_in  (sample_in),
    .code_in    (code_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_out   (code_out),
    .sample_out (sample_out),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random ready with short gaps, rare long stalls, ready runs, requested squeezes
  initial begin
    int hold;
    int run;
    int r;
    int squeezes_done;
    hold = 0;
    run = 0;
    squeezes_done = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (squeezes_done != squeeze_asks) begin
        squeezes_done++;
        out_ready <= 1'b0;
        hold = SQUEEZE_CYCLES - 1;
      end else if (run > 0) begin
        out_ready <= 1'b1;
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          out_ready <= 1'b0;
          hold = $urandom_range(8, 40);
        end else if (r < 8) begin
          out_ready <= 1'b1;
          run = $urandom_range(20, 60);
        end else begin
          out_ready <= (r >= 30);
        end
      end
    end
  end

  function automatic int next_gap();
    int r;
    if ($urandom_range(0, 39) == 0) quiet = ~quiet;
    if (flood > 0) begin
      flood--;
      return 0;
    end
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic signed [15:0] pick_sample();
    unique case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 128) - 64);
      2: return 16'($urandom_range(0, 16600) - 8300);
      default: begin
        if ($urandom_range(0, 1)) return 16'(-32768 + $urandom_range(0, 15));
        return 16'(32767 - $urandom_range(0, 15));
      end
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_word(logic o, logic signed [15:0] s, logic [7:0] c);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= o;
    sample_in <= s;
    code_in   <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (o == OP_ENC) encode_words++;
    else decode_words++;
    @(negedge clk);
  endtask

  task automatic write_law(logic l);
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_law   <= l;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    law_writes++;
  endtask

  task automatic run_corners();
    foreach (corner_samples[i]) send_word(OP_ENC, corner_samples[i], 8'($urandom));
    foreach (corner_codes[i]) send_word(OP_DEC, 16'($urandom), corner_codes[i]);
  endtask

  task automatic run_random(int count);
    squeeze_asks <= squeeze_asks + 1;
    flood = FLOOD_WORDS;
    repeat (count) send_word(logic'($urandom_range(0, 1)), pick_sample(), 8'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_corners();
    write_law(LAW_MU);
    run_corners();
    run_random(300);
    write_law(LAW_A);
    run_random(300);
    write_law(LAW_MU);
    run_random(280);
    write_law(LAW_A);
    run_random(270);
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d encode and %0d decode words over %0d law writes,", encode_words,
             decode_words, law_writes);
    $display("both laws, corner samples and codes, and %0d long output stalls", squeeze_asks);
    if (mismatches == 0 && words_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/g711_pkg.sv
rtl/g711_enc.sv
rtl/g711_companding_codec_core.sv
dv/g711_codec_checker.sv
dv/tb_g711_companding_codec_core.sv
